// ===== rtl/circular_fifo_queue_defines.svh =====
// ----------------------------------------------------------------------------
// circular_fifo_queue_defines.svh
// Assertion macros used by the checker of the circular FIFO queue.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_FIFO_QUEUE_DEFINES_SVH
`define CIRCULAR_FIFO_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define CFQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define CFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cfq_pkg.sv =====
// ----------------------------------------------------------------------------
// cfq_pkg
// Types and constants of the circular FIFO queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfq_pkg;

  localparam int DATA_W = 32;

  // Requested operation of an input beat; the fourth code is ignored.
  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_DISP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DEQ  = 2'd1,
    S_DISP = 2'd2
  } state_t;

  typedef struct packed {
    op_t                       operation;
    logic signed [DATA_W-1:0]  push_value;
  } in_beat_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  read_value;
    logic                      last;
  } out_beat_t;

endpackage

// ===== rtl/cfq_ram.sv =====
// ----------------------------------------------------------------------------
// cfq_ram
// Simple dual-port storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfq_ram
  import cfq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [DATA_W-1:0]          wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [DATA_W-1:0]          rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/circular_fifo_queue.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_queue
// Fixed-depth circular FIFO of signed 32-bit words with enqueue, dequeue and
// display operations, built around one synchronous storage memory.
// ----------------------------------------------------------------------------
// Each input beat carries one operation. An enqueue answers with one beat
// (ok, or full when DEPTH words are stored) and the block takes a new input
// beat in every cycle, unless the output is stalled, for enqueues and for a
// dequeue or display that meets an empty queue. A dequeue of a stored word
// reads the head entry from the memory in the accept cycle; the word then
// moves from the read register to the output register when that is free. A
// display of n stored words makes one read per cycle on the single read port
// and one output beat per cycle while the output is not stalled, oldest word
// first, with last set only on the newest. An empty queue answers a dequeue
// or a display with a single empty beat. The unused operation code is taken
// and produces nothing. The storage needs no clearing pass after reset: only
// entries written since they were last freed are ever read. A stalled output
// beat holds in the output register; the next input is then held off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circular_fifo_queue
  import cfq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  // Display walk: next entry to read and number of beats still to issue
  // after the one whose data is in the read register.
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [OCC_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_data_r, out_data_nxt;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic              out_free;
  logic              in_accept;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // The output register can take a new beat when it is empty or is being
  // drained at this edge.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  cfq_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = tail_r;
    wr_data       = in_data.push_value;
    rd_en         = 1'b0;
    rd_addr       = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_data.operation)
            OP_ENQ: begin
              out_valid_nxt = 1'b1;
              if (occ_r == OCC_W'(DEPTH)) begin
                out_data_nxt = '{status: ST_FULL, read_value: '0, last: 1'b1};
              end else begin
                out_data_nxt = '{status: ST_OK, read_value: '0, last: 1'b1};
                wr_en        = 1'b1;
                tail_nxt     = next_idx(tail_r);
                occ_nxt      = occ_r + OCC_W'(1);
              end
            end
            OP_DEQ: begin
              if (occ_r == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{status: ST_EMPTY, read_value: '0, last: 1'b1};
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_DEQ;
              end
            end
            OP_DISP: begin
              if (occ_r == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{status: ST_EMPTY, read_value: '0, last: 1'b1};
              end else begin
                rd_en     = 1'b1;
                idx_nxt   = next_idx(head_r);
                cnt_nxt   = occ_r - OCC_W'(1);
                state_nxt = S_DISP;
              end
            end
            default: begin
              // Unused code: the beat is consumed without any effect.
            end
          endcase
        end
      end
      S_DEQ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_OK, read_value: rd_data, last: 1'b1};
          head_nxt      = next_idx(head_r);
          occ_nxt       = occ_r - OCC_W'(1);
          state_nxt     = S_IDLE;
        end
      end
      S_DISP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_OK, read_value: rd_data, last: (cnt_r == '0)};
          if (cnt_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r;
            idx_nxt = next_idx(idx_r);
            cnt_nxt = cnt_r - OCC_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/cfq_checker.sv =====
// ----------------------------------------------------------------------------
// cfq_checker
// Port-level checks of the circular FIFO queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "circular_fifo_queue_defines.svh"

module cfq_checker
  import cfq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  localparam int OCC_W = $clog2(DEPTH + 1);

  logic [OCC_W-1:0] shadow_occ_r;
  logic             in_fire;

  assign in_fire = in_valid && !in_stall;

  // Occupancy as implied by the accepted input beats.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shadow_occ_r <= '0;
    end else if (in_fire) begin
      if (in_data.operation == OP_ENQ && shadow_occ_r != OCC_W'(DEPTH)) begin
        shadow_occ_r <= shadow_occ_r + OCC_W'(1);
      end else if (in_data.operation == OP_DEQ && shadow_occ_r != '0) begin
        shadow_occ_r <= shadow_occ_r - OCC_W'(1);
      end
    end
  end

  `CFQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled output beat changed")
  `CFQ_ASSERT_NOW(a_status_beat, out_valid && (out_data.status == ST_FULL || out_data.status == ST_EMPTY), out_data.last && out_data.read_value == '0, "status beat carries data or lacks last")
  `CFQ_ASSERT_NOW(a_full_when_full, out_valid && out_data.status == ST_FULL, shadow_occ_r == OCC_W'(DEPTH), "full reported with free slots")
  `CFQ_ASSERT_NOW(a_empty_when_empty, out_valid && out_data.status == ST_EMPTY, shadow_occ_r == '0, "empty reported with stored words")

endmodule

bind circular_fifo_queue cfq_checker #(.DEPTH(DEPTH)) u_cfq_checker (.*);
